[rtl/abmap_pkg.sv]
// shared constants, types and helpers for the arcade main bus map
package abmap_pkg;

  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned MainDepth  = 65536;
  localparam int unsigned NvDepth    = 2048;
  localparam int unsigned LevelWidth = 8;
  localparam int unsigned IndexWidth = 6;

  // operation codes
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_PRELOAD = 2'd2;

  localparam logic [DataWidth-1:0] UNMAPPED_BYTE = 8'hff;
  localparam logic [DataWidth-1:0] MAIN_FILL     = 8'hff;
  localparam logic [DataWidth-1:0] NV_FILL       = 8'h00;

  // controller to datapath
  typedef struct packed {
    logic clear_en;   // sweep one entry of the stores
    logic accept;     // take the request on the input ports
    logic load_out;   // load the result registers
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last; // sweep is on its final entry
  } status_t;

  // 3-bit level scaled by 36 (32 + 4)
  function automatic logic [LevelWidth-1:0] level3(input logic [2:0] v);
    level3 = {v, 5'b00000} + {3'b000, v, 2'b00};
  endfunction

endpackage

[rtl/abmap_ram.sv]
// generic single-port ram with registered read
module abmap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/abmap_ctrl.sv]
// sequencing controller: clearing sweep, request intake and result hand-off
module abmap_ctrl import abmap_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    cmd_o.clear_en   = 1'b0;
    cmd_o.accept     = 1'b0;
    cmd_o.load_out   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // wait for the result register to free up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/abmap_dp.sv]
// datapath: address decode, main and nvram stores, palette level math, result registers
module abmap_dp import abmap_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [1:0]            operation_i,
  input  logic [AddrWidth-1:0]  address_i,
  input  logic [DataWidth-1:0]  write_data_i,
  output logic [DataWidth-1:0]  read_data_o,
  output logic                  color_written_o,
  output logic [IndexWidth-1:0] color_index_o,
  output logic [LevelWidth-1:0] color_red_o,
  output logic [LevelWidth-1:0] color_green_o,
  output logic [LevelWidth-1:0] color_blue_o
);

  localparam int unsigned NvAddrWidth = $clog2(NvDepth);

  // clearing sweep counter
  logic [AddrWidth-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clear_en) begin
      clr_cnt_d = clr_cnt_q + AddrWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign status_o.clear_last = &clr_cnt_q;

  // region decode of a bus address
  function automatic logic is_rom(input logic [AddrWidth-1:0] a);
    is_rom = (a[15:13] != 3'b111);
  endfunction
  function automatic logic is_nv(input logic [AddrWidth-1:0] a);
    is_nv = (a[15:11] == 5'b11100);
  endfunction
  function automatic logic is_sprite(input logic [AddrWidth-1:0] a);
    is_sprite = (a[15:10] == 6'b111010);
  endfunction
  function automatic logic is_vram(input logic [AddrWidth-1:0] a);
    is_vram = (a[15:11] == 5'b11110);
  endfunction
  function automatic logic is_pal(input logic [AddrWidth-1:0] a);
    is_pal = (a[15:11] == 5'b11111);
  endfunction

  // store port control
  logic                   in_sprite;
  logic [AddrWidth-1:0]   bus_addr;
  logic                   main_we, main_re;
  logic [AddrWidth-1:0]   main_addr;
  logic [DataWidth-1:0]   main_wdata, main_rdata;
  logic                   nv_we, nv_re;
  logic [NvAddrWidth-1:0] nv_addr;
  logic [DataWidth-1:0]   nv_wdata, nv_rdata;

  assign in_sprite = is_sprite(address_i);
  // sprite window E800-E9FF, mirrored over E800-EBFF
  assign bus_addr  = in_sprite ? {7'b1110100, address_i[8:0]} : address_i;

  always_comb begin
    main_we    = 1'b0;
    main_re    = 1'b0;
    main_addr  = bus_addr;
    main_wdata = write_data_i;
    nv_we      = 1'b0;
    nv_re      = 1'b0;
    nv_addr    = address_i[NvAddrWidth-1:0];
    nv_wdata   = write_data_i;
    if (cmd_i.clear_en) begin
      main_we    = 1'b1;
      main_addr  = clr_cnt_q;
      main_wdata = MAIN_FILL;
      nv_we      = (clr_cnt_q[AddrWidth-1:NvAddrWidth] == '0);
      nv_addr    = clr_cnt_q[NvAddrWidth-1:0];
      nv_wdata   = NV_FILL;
    end else if (cmd_i.accept) begin
      main_re = (operation_i == OP_READ);
      nv_re   = (operation_i == OP_READ);
      if (operation_i == OP_PRELOAD) begin
        main_we   = 1'b1;
        main_addr = address_i;
      end else if (operation_i == OP_WRITE) begin
        main_we = in_sprite || is_vram(address_i);
        nv_we   = is_nv(address_i);
      end
    end
  end

  abmap_ram #(
    .Width (DataWidth),
    .Depth (MainDepth)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .re_i    (main_re),
    .addr_i  (main_addr),
    .wdata_i (main_wdata),
    .rdata_o (main_rdata)
  );

  abmap_ram #(
    .Width (DataWidth),
    .Depth (NvDepth)
  ) u_nv_ram (
    .clk_i   (clk_i),
    .we_i    (nv_we),
    .re_i    (nv_re),
    .addr_i  (nv_addr),
    .wdata_i (nv_wdata),
    .rdata_o (nv_rdata)
  );

  // request held while the store read completes
  logic [1:0]           op_q;
  logic [AddrWidth-1:0] addr_q;
  logic [DataWidth-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= operation_i;
      addr_q <= address_i;
      data_q <= write_data_i;
    end
  end

  // result formation
  logic [DataWidth-1:0]  read_data_d;
  logic                  color_written_d;
  logic [IndexWidth-1:0] color_index_d;
  logic [LevelWidth-1:0] color_red_d, color_green_d, color_blue_d;

  always_comb begin
    read_data_d     = '0;
    color_written_d = 1'b0;
    color_index_d   = '0;
    color_red_d     = '0;
    color_green_d   = '0;
    color_blue_d    = '0;
    if (op_q == OP_READ) begin
      if (is_rom(addr_q) || is_sprite(addr_q) || is_vram(addr_q)) begin
        read_data_d = main_rdata;
      end else if (is_nv(addr_q)) begin
        read_data_d = nv_rdata;
      end else begin
        read_data_d = UNMAPPED_BYTE;
      end
    end else if ((op_q == OP_WRITE) && is_pal(addr_q)) begin
      // 9-bit value: address bit 0 above the data byte
      color_written_d = 1'b1;
      color_index_d   = addr_q[6:1];
      color_red_d     = level3({addr_q[0], data_q[7:6]});
      color_green_d   = level3(data_q[2:0]);
      color_blue_d    = level3(data_q[5:3]);
    end
  end

  logic [DataWidth-1:0]  read_data_q;
  logic                  color_written_q;
  logic [IndexWidth-1:0] color_index_q;
  logic [LevelWidth-1:0] color_red_q, color_green_q, color_blue_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_q     <= read_data_d;
      color_written_q <= color_written_d;
      color_index_q   <= color_index_d;
      color_red_q     <= color_red_d;
      color_green_q   <= color_green_d;
      color_blue_q    <= color_blue_d;
    end
  end

  assign read_data_o     = read_data_q;
  assign color_written_o = color_written_q;
  assign color_index_o   = color_index_q;
  assign color_red_o     = color_red_q;
  assign color_green_o   = color_green_q;
  assign color_blue_o    = color_blue_q;

endmodule

[rtl/arcade_main_bus_map_with_palette_core.sv]
// top level of the arcade main cpu bus map with palette decode
//
//   channel  handshake                  payload
//   request  in_valid_i / in_ready_o    operation_i, address_i, write_data_i
//   result   out_valid_o / out_ready_i  read_data_o, color_written_o, color_index_o,
//                                       color_red_o, color_green_o, color_blue_o
//
// for each request the accept edge launches the store access; the result register is
// loaded from the registered ram read port in the lookup state, once it is free
// after reset a clearing pass fills the main store with 0xff (nvram is zeroed
// during the pass); in_ready_o stays low meanwhile
// a result that is not taken holds the next request in its lookup cycle;
// the request side may still hand over one request while a result waits
module arcade_main_bus_map_with_palette_core import abmap_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [AddrWidth-1:0]  address_i,
  input  logic [DataWidth-1:0]  write_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DataWidth-1:0]  read_data_o,
  output logic                  color_written_o,
  output logic [IndexWidth-1:0] color_index_o,
  output logic [LevelWidth-1:0] color_red_o,
  output logic [LevelWidth-1:0] color_green_o,
  output logic [LevelWidth-1:0] color_blue_o
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // controller: clear sweep, intake and hand-off of results
  abmap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath: stores, decode, palette levels (palette entries leave on the
  // result port; nothing reads them back, so no local copy is kept)
  abmap_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .operation_i     (operation_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .read_data_o     (read_data_o),
    .color_written_o (color_written_o),
    .color_index_o   (color_index_o),
    .color_red_o     (color_red_o),
    .color_green_o   (color_green_o),
    .color_blue_o    (color_blue_o)
  );

endmodule

[dv/tb_arcade_main_bus_map_with_palette_core.sv]
// testbench for the arcade main bus map: predicted results, random traffic, flow-control stress
`timescale 1ns / 100ps

module tb_arcade_main_bus_map_with_palette_core;
  import abmap_pkg::*;

  localparam int ClkHalf      = 4;
  localparam int HoldCycles   = 300;       // long result-side stall
  localparam int DrainCycles  = 8;         // margin after the last request
  localparam int RandomItems  = 1000;
  localparam int StreamItems  = 100;

  // the package names three operations, the fourth code is a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // memory map
  localparam logic [AddrWidth-1:0] ROM_TOP      = 16'hdfff;
  localparam logic [AddrWidth-1:0] NV_BASE      = 16'he000;
  localparam logic [AddrWidth-1:0] NV_TOP       = 16'he7ff;
  localparam logic [AddrWidth-1:0] SPRITE_BASE  = 16'he800;
  localparam logic [AddrWidth-1:0] SPRITE_TOP   = 16'hebff;
  localparam logic [AddrWidth-1:0] HOLE_BASE    = 16'hec00;
  localparam logic [AddrWidth-1:0] VIDEO_BASE   = 16'hf000;
  localparam logic [AddrWidth-1:0] VIDEO_TOP    = 16'hf7ff;
  localparam logic [AddrWidth-1:0] PALETTE_BASE = 16'hf800;
  localparam logic [AddrWidth-1:0] ADDR_MAX     = 16'hffff;
  localparam logic [AddrWidth-1:0] SPRITE_MASK  = 16'h01ff;
  localparam logic [AddrWidth-1:0] SPRITE_ALIAS = 16'h0200;
  localparam logic [AddrWidth-1:0] NV_MASK      = 16'h07ff;
  localparam logic [AddrWidth-1:0] ROM_POOL     = 16'h0100;
  localparam logic [LevelWidth-1:0] LEVEL_STEP  = 8'd36;

  typedef struct packed {
    logic [DataWidth-1:0]  read_data;
    logic                  color_written;
    logic [IndexWidth-1:0] color_index;
    logic [LevelWidth-1:0] red;
    logic [LevelWidth-1:0] green;
    logic [LevelWidth-1:0] blue;
  } bus_result_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            operation_i  = OP_READ;
  logic [AddrWidth-1:0]  address_i    = '0;
  logic [DataWidth-1:0]  write_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [DataWidth-1:0]  read_data_o;
  logic                  color_written_o;
  logic [IndexWidth-1:0] color_index_o;
  logic [LevelWidth-1:0] color_red_o;
  logic [LevelWidth-1:0] color_green_o;
  logic [LevelWidth-1:0] color_blue_o;

  // shadow copies of the block's stores, plus the palette entries it reports
  logic [DataWidth-1:0]    main_image    [MainDepth];
  logic [DataWidth-1:0]    nv_image      [NvDepth];
  logic [3*LevelWidth-1:0] palette_image [64];

  bus_result_t pending_results [$];
  bus_result_t oldest_result;
  logic        mismatch_seen = 1'b0;

  // knobs shared between the test tasks and the two sides
  logic src_idle_en  = 1'b1;
  logic sink_idle_en = 1'b1;
  logic hold_request = 1'b0;

  arcade_main_bus_map_with_palette_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .address_i,
    .write_data_i,
    .out_valid_o,
    .out_ready_i,
    .read_data_o,
    .color_written_o,
    .color_index_o,
    .color_red_o,
    .color_green_o,
    .color_blue_o
  );

  always #ClkHalf clk_i = ~clk_i;

  // apply one access to the shadow stores and work out the result it gives
  function automatic bus_result_t predict_access(input logic [1:0] op,
                                                 input logic [AddrWidth-1:0] addr,
                                                 input logic [DataWidth-1:0] data);
    bus_result_t res;
    logic [8:0]  color_val;
    res = '0;
    case (op)
      OP_READ: begin
        if (addr <= ROM_TOP) begin
          res.read_data = main_image[addr];
        end else if (addr <= NV_TOP) begin
          res.read_data = nv_image[addr & NV_MASK];
        end else if (addr <= SPRITE_TOP) begin
          // sprite window is 512 bytes, seen twice
          res.read_data = main_image[SPRITE_BASE | (addr & SPRITE_MASK)];
        end else if (addr >= VIDEO_BASE && addr <= VIDEO_TOP) begin
          res.read_data = main_image[addr];
        end else begin
          // hole and write-only palette
          res.read_data = UNMAPPED_BYTE;
        end
      end
      OP_WRITE: begin
        // rom and the hole drop bus writes
        if (addr > ROM_TOP && addr <= NV_TOP) begin
          nv_image[addr & NV_MASK] = data;
        end else if (addr > NV_TOP && addr <= SPRITE_TOP) begin
          main_image[SPRITE_BASE | (addr & SPRITE_MASK)] = data;
        end else if (addr >= VIDEO_BASE && addr <= VIDEO_TOP) begin
          main_image[addr] = data;
        end else if (addr >= PALETTE_BASE) begin
          // address bit 0 is the ninth color bit
          color_val         = {addr[0], data};
          res.color_written = 1'b1;
          res.color_index   = addr[6:1];
          res.red           = {5'd0, color_val[8:6]} * LEVEL_STEP;
          res.green         = {5'd0, color_val[2:0]} * LEVEL_STEP;
          res.blue          = {5'd0, color_val[5:3]} * LEVEL_STEP;
          palette_image[addr[6:1]] = {res.red, res.green, res.blue};
        end
      end
      OP_PRELOAD: begin
        main_image[addr] = data;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // hand one request to the block, with an optional gap first
  task automatic send_access(input logic [1:0] op, input logic [AddrWidth-1:0] addr,
                             input logic [DataWidth-1:0] data);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), predict_access(op, addr, data));
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // pick an address, pooled half the time in the rom, nvram, sprite and video regions so reads hit earlier writes
  function automatic logic [AddrWidth-1:0] pick_address();
    logic pooled;
    logic [AddrWidth-1:0] a;
    pooled = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 6))
      0: a = pooled ? ROM_POOL + 16'($urandom_range(0, 15)) : 16'($urandom_range(0, ROM_TOP));
      1: a = NV_BASE + (pooled ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, NV_MASK)));
      2: a = SPRITE_BASE + (pooled ? 16'($urandom_range(0, 1)) * SPRITE_ALIAS
                                     + 16'($urandom_range(0, 15))
                                   : 16'($urandom_range(0, SPRITE_TOP - SPRITE_BASE)));
      3: a = 16'($urandom_range(HOLE_BASE, VIDEO_BASE - 1));
      4: a = VIDEO_BASE + (pooled ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, NV_MASK)));
      5: a = 16'($urandom_range(PALETTE_BASE, ADDR_MAX));
      default: a = 16'($urandom());
    endcase
    return a;
  endfunction

  function automatic logic [1:0] pick_operation();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return OP_READ;
    else if (sel < 15) return OP_WRITE;
    else if (sel < 19) return OP_PRELOAD;
    return OP_UNUSED;
  endfunction

  // each region, each operation and the corner cases of the map
  task automatic test_directed();
    send_access(OP_READ,    16'h0000,     8'h00);  // rom after reset reads ff
    send_access(OP_PRELOAD, 16'h0000,     8'h00);
    send_access(OP_READ,    16'h0000,     8'hff);
    send_access(OP_PRELOAD, ROM_TOP,      8'ha5);
    send_access(OP_WRITE,   ROM_TOP,      8'h00);  // rom write is dropped
    send_access(OP_READ,    ROM_TOP,      8'h00);
    send_access(OP_READ,    NV_BASE,      8'h00);  // nvram starts zero
    send_access(OP_WRITE,   NV_TOP,       8'h5a);
    send_access(OP_PRELOAD, NV_BASE,      8'h11);  // preload misses nvram
    send_access(OP_READ,    NV_BASE,      8'h00);
    send_access(OP_READ,    NV_TOP,       8'h00);
    send_access(OP_WRITE,   SPRITE_BASE,  8'h3c);
    send_access(OP_READ,    16'hea00,     8'h00);  // upper sprite alias
    send_access(OP_PRELOAD, 16'hea01,     8'h77);  // lands outside the window
    send_access(OP_READ,    16'hea01,     8'h00);
    send_access(OP_WRITE,   HOLE_BASE,    8'h12);  // hole drops writes
    send_access(OP_READ,    16'hefff,     8'h00);  // hole reads ff
    send_access(OP_WRITE,   VIDEO_BASE,   8'h80);
    send_access(OP_PRELOAD, VIDEO_TOP,    8'h01);
    send_access(OP_READ,    VIDEO_TOP,    8'h00);
    send_access(OP_WRITE,   PALETTE_BASE, 8'h00);  // black, entry 0
    send_access(OP_WRITE,   ADDR_MAX,     8'hff);  // full white, entry 63
    send_access(OP_PRELOAD, PALETTE_BASE, 8'h00);  // palette still unreadable
    send_access(OP_READ,    PALETTE_BASE, 8'h00);
    send_access(OP_UNUSED,  ADDR_MAX,     8'hff);
    wait_for_results();
  endtask

  // result side stalls for a long stretch while requests keep coming
  task automatic test_output_hold();
    src_idle_en  = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_access(pick_operation(), pick_address(), 8'($urandom_range(0, 255)));
    end
    wait_for_results();
    src_idle_en = 1'b1;
  endtask

  // random accesses; a write or preload is often followed by a read of the same address
  task automatic test_random_traffic(input int count);
    logic [1:0]           op;
    logic [AddrWidth-1:0] addr;
    int                   sent;
    sent = 0;
    while (sent < count) begin
      op   = pick_operation();
      addr = pick_address();
      send_access(op, addr, 8'($urandom_range(0, 255)));
      sent++;
      if ((op == OP_WRITE || op == OP_PRELOAD) && $urandom_range(0, 2) != 0) begin
        send_access(OP_READ, addr, 8'($urandom_range(0, 255)));
        sent++;
      end
    end
    wait_for_results();
  endtask

  // back to back traffic, no gaps on either side
  task automatic test_streaming();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(StreamItems);
  endtask

  // result side: random stalls, or a long hold when asked
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endfunction

  // compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, read_data %0d", $time, read_data_o);
        mismatch_seen = 1'b1;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("read_data",     oldest_result.read_data,     read_data_o);
        check_field("color_written", oldest_result.color_written, color_written_o);
        check_field("color_index",   oldest_result.color_index,   color_index_o);
        check_field("color_red",     oldest_result.red,           color_red_o);
        check_field("color_green",   oldest_result.green,         color_green_o);
        check_field("color_blue",    oldest_result.blue,          color_blue_o);
      end
    end
  end

  initial begin
    foreach (main_image[i]) main_image[i] = MAIN_FILL;
    foreach (nv_image[i]) nv_image[i] = NV_FILL;
    foreach (palette_image[i]) palette_image[i] = '0;
    // the clearing pass after reset shows up as a long wait for in_ready_o
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_output_hold();
    test_random_traffic(RandomItems);
    test_streaming();
    repeat (DrainCycles) @(posedge clk_i);
    if (!mismatch_seen && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // covers the clearing pass plus every request at its slowest, several times over
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/abmap_pkg.sv
rtl/abmap_ram.sv
rtl/abmap_ctrl.sv
rtl/abmap_dp.sv
rtl/arcade_main_bus_map_with_palette_core.sv
dv/tb_arcade_main_bus_map_with_palette_core.sv
